// ----- src/matrix_chain_order_cost_macros.svh -----
// ----------------------------------------------------------------------------
// matrix chain order cost: assertion macros
// Checks are compiled unless SYNTH is defined, then they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef MATRIX_CHAIN_ORDER_COST_MACROS_SVH
`define MATRIX_CHAIN_ORDER_COST_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MCOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MCOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MCOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/mcoc_pkg.sv -----
// ----------------------------------------------------------------------------
// mcoc_pkg
// Shared constants, types and the saturating adder of the chain order block.
// ----------------------------------------------------------------------------
package mcoc_pkg;

    // defaults and fixed field widths
    localparam int MCOC_MAX_MATRICES = 16;
    localparam int MCOC_DIM_WIDTH    = 16;
    localparam int DIM_IN_W          = 16;
    localparam int COST_W            = 63;
    localparam int SPLIT_W           = 4;
    localparam int STATUS_W          = 2;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_MANY = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CELL_A,
        S_CELL_B,
        S_CELL_C,
        S_K_RD,
        S_K_M0,
        S_K_M1,
        S_K_ADD0,
        S_K_ADD1,
        S_K_ADD2,
        S_K_CMP,
        S_CELL_WR,
        S_DONE
    } t_state;

    // multiplier operand select
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_DIM,
        MUL_LO,
        MUL_HI
    } t_mul_sel;

    // adder operand select
    typedef enum logic [1:0] {
        ADD_NONE,
        ADD_ACC,
        ADD_COST,
        ADD_PROD
    } t_add_sel;

    // sequencer to datapath controls
    typedef struct packed {
        logic     dim_we;
        logic     dim_re;
        logic     pi_load;
        logic     cost_re;
        logic     cost_we;
        t_mul_sel mul_sel;
        t_add_sel add_sel;
        logic     zero_left;
        logic     zero_right;
        logic     cmp_en;
        logic     first_k;
        logic     res_clear;
        logic     out_load;
        t_status  status;
    } t_ctrl;

    // saturating sum with overflow flag
    typedef struct packed {
        logic              ovf;
        logic [COST_W-1:0] val;
    } t_sum;

    function automatic t_sum sat_add(input logic [COST_W-1:0] a,
                                     input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        t_sum            r;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COST_MAX}) begin
            r.ovf = 1'b1;
            r.val = COST_MAX;
        end else begin
            r.ovf = 1'b0;
            r.val = s[COST_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- src/mcoc_in_if.sv -----
// ----------------------------------------------------------------------------
// mcoc_in_if
// Dimension channel: one dimension word per handshake, last one flagged.
// ----------------------------------------------------------------------------
interface mcoc_in_if;
    import mcoc_pkg::*;

    logic                valid;
    logic                ready;
    logic [DIM_IN_W-1:0] dimension;
    logic                last_dimension;

    modport source (output valid, output dimension, output last_dimension, input ready);
    modport sink   (input valid, input dimension, input last_dimension, output ready);
endinterface

// ----- src/mcoc_out_if.sv -----
// ----------------------------------------------------------------------------
// mcoc_out_if
// Result channel: minimum cost, top split, overflow flag and status.
// ----------------------------------------------------------------------------
interface mcoc_out_if;
    import mcoc_pkg::*;

    logic                valid;
    logic                ready;
    logic [COST_W-1:0]   min_cost;
    logic [SPLIT_W-1:0]  top_split;
    logic                cost_overflow;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output min_cost, output top_split, output cost_overflow,
                    output status, input ready);
    modport sink   (input valid, input min_cost, input top_split, input cost_overflow,
                    input status, output ready);
endinterface

// ----- src/mcoc_seq.sv -----
// ----------------------------------------------------------------------------
// mcoc_seq
// Loads the dimension list and steps the interval program: sub-chain length,
// start index and split index, one datapath operation per state.
// ----------------------------------------------------------------------------
`include "matrix_chain_order_cost_macros.svh"

module mcoc_seq #(
    parameter int MAX_MATRICES = mcoc_pkg::MCOC_MAX_MATRICES
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    mcoc_in_if.sink                                    i_in,
    input  logic                                       i_out_free,
    output mcoc_pkg::t_ctrl                            o_ctrl,
    output logic [$clog2(MAX_MATRICES+1)-1:0]          o_dim_waddr,
    output logic [$clog2(MAX_MATRICES+1)-1:0]          o_dim_raddr,
    output logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] o_cost_raddr0,
    output logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] o_cost_raddr1,
    output logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] o_cost_waddr,
    output logic [$clog2(MAX_MATRICES)-1:0]            o_k_idx
);
    import mcoc_pkg::*;

    localparam int DIM_DEPTH = MAX_MATRICES + 1;
    localparam int DAW       = $clog2(DIM_DEPTH);
    localparam int CW        = $clog2(DIM_DEPTH + 1);
    localparam int LW        = $clog2(MAX_MATRICES + 1);
    localparam int IW        = $clog2(MAX_MATRICES);
    localparam int CAW       = $clog2(MAX_MATRICES * MAX_MATRICES);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_many, n_many;
    logic [LW-1:0]   r_n, n_n;
    logic [LW-1:0]   r_len, n_len;
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_k, n_k;
    t_status         r_status, n_status;
    t_ctrl           ctrl;

    logic [LW-1:0]   j_l;
    logic [IW-1:0]   j;
    logic [LW-1:0]   k_next;
    logic            last_i;
    logic            k_last;

    // interval indices
    assign j_l    = LW'(r_i) + r_len - LW'(1);
    assign j      = IW'(j_l);
    assign k_next = LW'(r_k) + LW'(1);
    assign last_i = (LW'(r_i) + r_len) == r_n;
    assign k_last = k_next == j_l;

    // table addresses, row major
    assign o_cost_raddr0 = CAW'(r_i) * CAW'(MAX_MATRICES) + CAW'(r_k);
    assign o_cost_raddr1 = CAW'(IW'(k_next)) * CAW'(MAX_MATRICES) + CAW'(j);
    assign o_cost_waddr  = CAW'(r_i) * CAW'(MAX_MATRICES) + CAW'(j);
    assign o_dim_waddr   = DAW'(r_count);
    assign o_k_idx       = r_k;
    assign o_ctrl        = ctrl;

    // ready only while loading
    assign i_in.ready = (r_state == S_IDLE);

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_many   <= 1'b0;
            r_n      <= '0;
            r_len    <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_many   <= n_many;
            r_n      <= n_n;
            r_len    <= n_len;
            r_i      <= n_i;
            r_k      <= n_k;
            r_status <= n_status;
        end
    end

    // next state and controls
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_many      = r_many;
        n_n         = r_n;
        n_len       = r_len;
        n_i         = r_i;
        n_k         = r_k;
        n_status    = r_status;
        ctrl        = '0;
        ctrl.status = r_status;
        o_dim_raddr = DAW'(r_i);
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (r_count < CW'(DIM_DEPTH)) begin
                        ctrl.dim_we = 1'b1;
                        n_count     = r_count + CW'(1);
                    end else begin
                        n_many = 1'b1;
                    end
                    if (i_in.last_dimension) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                ctrl.res_clear = 1'b1;
                n_n            = LW'(r_count - CW'(1));
                if (r_count < CW'(2)) begin
                    n_status = ST_FEW;
                    n_state  = S_DONE;
                end else begin
                    n_status = r_many ? ST_MANY : ST_OK;
                    n_len    = LW'(2);
                    n_i      = '0;
                    n_state  = (r_count == CW'(2)) ? S_DONE : S_CELL_A;
                end
            end
            S_CELL_A: begin
                ctrl.dim_re = 1'b1;
                o_dim_raddr = DAW'(r_i);
                n_state     = S_CELL_B;
            end
            S_CELL_B: begin
                ctrl.pi_load = 1'b1;
                ctrl.dim_re  = 1'b1;
                o_dim_raddr  = DAW'(j_l + LW'(1));
                n_state      = S_CELL_C;
            end
            S_CELL_C: begin
                ctrl.mul_sel = MUL_DIM;
                n_k          = r_i;
                n_state      = S_K_RD;
            end
            S_K_RD: begin
                ctrl.dim_re  = 1'b1;
                ctrl.cost_re = 1'b1;
                o_dim_raddr  = DAW'(k_next);
                n_state      = S_K_M0;
            end
            S_K_M0: begin
                ctrl.mul_sel = MUL_LO;
                n_state      = S_K_M1;
            end
            S_K_M1: begin
                ctrl.mul_sel = MUL_HI;
                n_state      = S_K_ADD0;
            end
            S_K_ADD0: begin
                ctrl.add_sel = ADD_ACC;
                n_state      = S_K_ADD1;
            end
            S_K_ADD1: begin
                // diagonal entries read as zero
                ctrl.add_sel    = ADD_COST;
                ctrl.zero_left  = (r_k == r_i);
                ctrl.zero_right = k_last;
                n_state         = S_K_ADD2;
            end
            S_K_ADD2: begin
                ctrl.add_sel = ADD_PROD;
                n_state      = S_K_CMP;
            end
            S_K_CMP: begin
                ctrl.cmp_en  = 1'b1;
                ctrl.first_k = (r_k == r_i);
                if (k_last) begin
                    n_state = S_CELL_WR;
                end else begin
                    n_k     = IW'(k_next);
                    n_state = S_K_RD;
                end
            end
            S_CELL_WR: begin
                ctrl.cost_we = 1'b1;
                if (last_i) begin
                    if (r_len == r_n) begin
                        n_state = S_DONE;
                    end else begin
                        n_len   = r_len + LW'(1);
                        n_i     = '0;
                        n_state = S_CELL_A;
                    end
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_CELL_A;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    ctrl.out_load = 1'b1;
                    n_count       = '0;
                    n_many        = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks
    `MCOC_ASSERT_IMP(a_dim_in_range, i_clk, i_rst_n, ctrl.dim_we, r_count < CW'(DIM_DEPTH), "dimension write beyond store")
    `MCOC_ASSERT_IMP(a_split_in_cell, i_clk, i_rst_n, r_state == S_K_CMP, LW'(r_k) < j_l, "split index outside sub-chain")
    `MCOC_ASSERT_NXT(a_count_cleared, i_clk, i_rst_n, ctrl.out_load, (r_count == '0) && !r_many, "chain state not cleared after result")
    `MCOC_ASSERT_IMP(a_wait_for_output, i_clk, i_rst_n, (r_state == S_DONE) && !i_out_free, n_state == S_DONE, "result issued while output busy")

endmodule

// ----- src/mcoc_dp.sv -----
// ----------------------------------------------------------------------------
// mcoc_dp
// Datapath: dimension store, cost table, one shared multiplier, one shared
// saturating adder, best-split tracking and the result register.
// ----------------------------------------------------------------------------
`include "matrix_chain_order_cost_macros.svh"

module mcoc_dp #(
    parameter int MAX_MATRICES = mcoc_pkg::MCOC_MAX_MATRICES,
    parameter int DIM_WIDTH    = mcoc_pkg::MCOC_DIM_WIDTH
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  mcoc_pkg::t_ctrl                              i_ctrl,
    input  logic [DIM_WIDTH-1:0]                         i_dim_wdata,
    input  logic [$clog2(MAX_MATRICES+1)-1:0]            i_dim_waddr,
    input  logic [$clog2(MAX_MATRICES+1)-1:0]            i_dim_raddr,
    input  logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] i_cost_raddr0,
    input  logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] i_cost_raddr1,
    input  logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] i_cost_waddr,
    input  logic [$clog2(MAX_MATRICES)-1:0]              i_k_idx,
    mcoc_out_if.source                                   o_out,
    output logic                                         o_out_free
);
    import mcoc_pkg::*;

    localparam int DIM_DEPTH  = MAX_MATRICES + 1;
    localparam int COST_DEPTH = MAX_MATRICES * MAX_MATRICES;
    localparam int IW         = $clog2(MAX_MATRICES);
    localparam int PW         = 2 * DIM_WIDTH;
    localparam int ACC_W      = 3 * DIM_WIDTH;

    logic [DIM_WIDTH-1:0] dim_mem  [DIM_DEPTH];
    logic [COST_W-1:0]    cost_mem [COST_DEPTH];

    logic [DIM_WIDTH-1:0] r_dim_q;
    logic [DIM_WIDTH-1:0] r_pi;
    logic [PW-1:0]        r_a;
    logic [ACC_W-1:0]     r_acc;
    logic [PW-1:0]        r_mul;
    logic [COST_W-1:0]    r_c0, r_c1;
    logic [COST_W-1:0]    r_sum;
    logic [COST_W-1:0]    r_q;
    logic [COST_W-1:0]    r_best;
    logic [IW-1:0]        r_bestk;
    logic                 r_ovf;

    logic                 r_out_valid;
    logic [COST_W-1:0]    r_out_cost;
    logic [SPLIT_W-1:0]   r_out_split;
    logic                 r_out_ovf;
    t_status              r_out_status;

    logic [DIM_WIDTH-1:0] mul_a;
    logic [PW-1:0]        mul_p;
    logic [COST_W-1:0]    add_a, add_b;
    t_sum                 sum;

    // dimension store, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.dim_we) begin
            dim_mem[i_dim_waddr] <= i_dim_wdata;
        end
        if (i_ctrl.dim_re) begin
            r_dim_q <= dim_mem[i_dim_raddr];
        end
    end

    // cost table, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cost_we) begin
            cost_mem[i_cost_waddr] <= r_best;
        end
        if (i_ctrl.cost_re) begin
            r_c0 <= cost_mem[i_cost_raddr0];
            r_c1 <= cost_mem[i_cost_raddr1];
        end
    end

    // shared multiplier
    always_comb begin
        unique case (i_ctrl.mul_sel)
            MUL_DIM: mul_a = r_pi;
            MUL_LO:  mul_a = r_a[DIM_WIDTH-1:0];
            MUL_HI:  mul_a = r_a[PW-1:DIM_WIDTH];
            default: mul_a = '0;
        endcase
        mul_p = mul_a * r_dim_q;
    end

    // shared saturating adder
    always_comb begin
        add_a = '0;
        add_b = '0;
        unique case (i_ctrl.add_sel)
            ADD_ACC: begin
                add_a = COST_W'(r_acc);
                add_b = COST_W'({r_mul, {DIM_WIDTH{1'b0}}});
            end
            ADD_COST: begin
                add_a = i_ctrl.zero_left  ? '0 : r_c0;
                add_b = i_ctrl.zero_right ? '0 : r_c1;
            end
            ADD_PROD: begin
                add_a = r_sum;
                add_b = COST_W'(r_acc);
            end
            default: begin
            end
        endcase
        sum = sat_add(add_a, add_b);
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.pi_load) begin
            r_pi <= r_dim_q;
        end
        unique case (i_ctrl.mul_sel)
            MUL_DIM: r_a   <= mul_p;
            MUL_LO:  r_acc <= ACC_W'(mul_p);
            MUL_HI:  r_mul <= mul_p;
            default: begin
            end
        endcase
        unique case (i_ctrl.add_sel)
            ADD_ACC:  r_acc <= ACC_W'(sum.val);
            ADD_COST: r_sum <= sum.val;
            ADD_PROD: r_q   <= sum.val;
            default: begin
            end
        endcase
        // best split, first lowest kept on ties
        if (i_ctrl.res_clear) begin
            r_best  <= '0;
            r_bestk <= '0;
        end else if (i_ctrl.cmp_en && (i_ctrl.first_k || (r_q < r_best))) begin
            r_best  <= r_q;
            r_bestk <= i_k_idx;
        end
    end

    // overflow seen during this chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_ovf <= 1'b0;
        end else if (((i_ctrl.add_sel == ADD_COST) || (i_ctrl.add_sel == ADD_PROD)) && sum.ovf) begin
            r_ovf <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_cost   <= r_best;
            r_out_split  <= SPLIT_W'(r_bestk);
            r_out_ovf    <= r_ovf;
            r_out_status <= i_ctrl.status;
        end
    end

    assign o_out_free          = !r_out_valid || o_out.ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.min_cost      = r_out_cost;
    assign o_out.top_split     = r_out_split;
    assign o_out.cost_overflow = r_out_ovf;
    assign o_out.status        = r_out_status;

    // checks
    `MCOC_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, i_ctrl.out_load, o_out_free, "result overwrites pending word")
    `MCOC_ASSERT_NXT(a_first_split_taken, i_clk, i_rst_n, i_ctrl.cmp_en && i_ctrl.first_k, r_best == $past(r_q), "first split not recorded")
    `MCOC_ASSERT_NXT(a_ovf_cleared, i_clk, i_rst_n, i_ctrl.out_load, !r_ovf, "overflow flag not cleared after result")

endmodule

// ----- src/matrix_chain_order_cost.sv -----
// ----------------------------------------------------------------------------
// matrix_chain_order_cost
// Minimum scalar-multiplication cost of a matrix chain by the interval
// dynamic program, with the top-level split and a status code.
//
//   channel | dir | word                                       | handshake
//   i_in    | in  | dimension, last_dimension                  | valid/ready
//   o_out   | out | min_cost, top_split, cost_overflow, status  | valid/ready
//
// Loading accepts one dimension per cycle while idle. After the last
// dimension the block runs the interval program: each split takes seven steps
// of the one multiplier and the one saturating adder, each sub-chain four more
// for its operand reads, first product and table write. Reset is synchronous;
// no clearing pass: every off-diagonal entry is written before it is read,
// diagonal entries read as zero. A result waits in the output register;
// the next chain loads meanwhile; its result waits until that register is free.
// ----------------------------------------------------------------------------
module matrix_chain_order_cost #(
    parameter int MAX_MATRICES = mcoc_pkg::MCOC_MAX_MATRICES,
    parameter int DIM_WIDTH    = mcoc_pkg::MCOC_DIM_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcoc_in_if.sink     i_in,
    mcoc_out_if.source  o_out
);
    import mcoc_pkg::*;

    localparam int DAW = $clog2(MAX_MATRICES + 1);
    localparam int CAW = $clog2(MAX_MATRICES * MAX_MATRICES);
    localparam int IW  = $clog2(MAX_MATRICES);

    t_ctrl                ctrl;
    logic                 out_free;
    logic [DAW-1:0]       dim_waddr, dim_raddr;
    logic [CAW-1:0]       cost_raddr0, cost_raddr1, cost_waddr;
    logic [IW-1:0]        k_idx;
    logic [DIM_WIDTH-1:0] dim_wdata;

    // low dimension bits kept
    assign dim_wdata = DIM_WIDTH'(i_in.dimension);

    // sequencer
    mcoc_seq #(
        .MAX_MATRICES (MAX_MATRICES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_out_free    (out_free),
        .o_ctrl        (ctrl),
        .o_dim_waddr   (dim_waddr),
        .o_dim_raddr   (dim_raddr),
        .o_cost_raddr0 (cost_raddr0),
        .o_cost_raddr1 (cost_raddr1),
        .o_cost_waddr  (cost_waddr),
        .o_k_idx       (k_idx)
    );

    // datapath
    mcoc_dp #(
        .MAX_MATRICES (MAX_MATRICES),
        .DIM_WIDTH    (DIM_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_dim_wdata   (dim_wdata),
        .i_dim_waddr   (dim_waddr),
        .i_dim_raddr   (dim_raddr),
        .i_cost_raddr0 (cost_raddr0),
        .i_cost_raddr1 (cost_raddr1),
        .i_cost_waddr  (cost_waddr),
        .i_k_idx       (k_idx),
        .o_out         (o_out),
        .o_out_free    (out_free)
    );

endmodule
